>>> design/esd_pkg.sv
// package for the escaped delta sample decoder: types, codes and constants
package esd_pkg;

    // default width of the frame sample counter
    localparam int FRAME_COUNT_BITS_DEF = 16;
    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_SAMPLES   = 2'd0;
    localparam logic [1:0] CFG_MAX_DELTA_BYTES = 2'd1;
    localparam logic [1:0] CFG_GAIN            = 2'd2;

    // configuration reset values
    localparam logic [15:0] FRAME_SAMPLES_RST   = 16'd1;
    localparam logic [2:0]  MAX_DELTA_BYTES_RST = 3'd4;
    localparam logic [31:0] GAIN_RST            = 32'h0100_0000;

    // escape codes and width settings
    localparam logic [7:0]  ESC_BYTE  = 8'h7F;
    localparam logic [15:0] ESC_WORD  = 16'h7FFF;
    localparam logic [2:0]  MDB_TWO   = 3'd2;
    localparam logic [2:0]  MDB_THREE = 3'd3;

    // fixed-point position of the gain
    localparam int GAIN_FRAC_BITS = 24;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC16,
        PH_WIDE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_SURPLUS = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] raw_value;
        logic signed [39:0] scaled_value;
        logic               sample_valid;
        logic               frame_end;
        t_status            status;
    } t_out_beat;

    // decoded record handed from front to back
    typedef struct packed {
        logic signed [31:0] raw_value;
        logic               sample_valid;
        logic               frame_end;
        t_status            status;
    } t_rec;

endpackage

>>> design/esd_front.sv
// front end: byte parser, delta accumulator and frame bookkeeping
module esd_front #(
    parameter int FRAME_COUNT_BITS = esd_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  esd_pkg::t_in_beat i_data,
    input  logic [15:0]      i_frame_samples,
    input  logic [2:0]       i_max_delta_bytes,
    output logic             o_rec_valid,
    input  logic             i_rec_ready,
    output esd_pkg::t_rec    o_rec
);

    localparam int CMP_W = (FRAME_COUNT_BITS > 16) ? FRAME_COUNT_BITS : 16;

    esd_pkg::t_phase             r_phase, n_phase;
    logic [31:0]                 r_gath, n_gath;
    logic [1:0]                  r_gcnt, n_gcnt;
    logic [31:0]                 r_acc, n_acc;
    logic [FRAME_COUNT_BITS-1:0] r_done, n_done;
    logic                        r_surplus, n_surplus;

    logic        fire;
    logic        have;
    logic [31:0] delta;
    logic [31:0] gath_or;
    logic [15:0] word;
    logic        frame_full;

    // one byte taken whenever the queue has room
    assign o_ready = i_rec_ready;
    assign fire    = i_valid && i_rec_ready;

    assign frame_full = CMP_W'(r_done) >= CMP_W'(i_frame_samples);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= esd_pkg::PH_IDLE;
            r_gath    <= '0;
            r_gcnt    <= '0;
            r_acc     <= '0;
            r_done    <= '0;
            r_surplus <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_gath    <= n_gath;
            r_gcnt    <= n_gcnt;
            r_acc     <= n_acc;
            r_done    <= n_done;
            r_surplus <= n_surplus;
        end
    end

    // parser next state and record
    always_comb begin
        n_phase   = r_phase;
        n_gath    = r_gath;
        n_gcnt    = r_gcnt;
        n_acc     = r_acc;
        n_done    = r_done;
        n_surplus = r_surplus;
        have      = 1'b0;
        delta     = '0;
        gath_or   = '0;
        word      = '0;
        o_rec_valid       = 1'b0;
        o_rec.raw_value   = '0;
        o_rec.sample_valid = 1'b0;
        o_rec.frame_end   = 1'b0;
        o_rec.status      = esd_pkg::ST_OK;

        if (fire) begin
            if (frame_full) begin
                // frame already complete: drop the byte
                n_surplus = 1'b1;
            end else begin
                unique case (r_phase)
                    esd_pkg::PH_IDLE: begin
                        if (i_data.data_byte == esd_pkg::ESC_BYTE) begin
                            n_phase = esd_pkg::PH_ESC16;
                            n_gath  = '0;
                            n_gcnt  = '0;
                        end else begin
                            delta = {{24{i_data.data_byte[7]}}, i_data.data_byte};
                            have  = 1'b1;
                        end
                    end
                    esd_pkg::PH_ESC16: begin
                        gath_or = r_gath | ({24'b0, i_data.data_byte} << {r_gcnt[0], 3'b000});
                        if (r_gcnt == 2'd0) begin
                            n_gath = gath_or;
                            n_gcnt = 2'd1;
                        end else begin
                            word = gath_or[15:0];
                            if (word != esd_pkg::ESC_WORD ||
                                i_max_delta_bytes == esd_pkg::MDB_TWO) begin
                                delta   = {{16{word[15]}}, word};
                                have    = 1'b1;
                                n_phase = esd_pkg::PH_IDLE;
                            end else begin
                                n_phase = esd_pkg::PH_WIDE;
                            end
                            n_gath = '0;
                            n_gcnt = '0;
                        end
                    end
                    esd_pkg::PH_WIDE: begin
                        gath_or = r_gath | ({24'b0, i_data.data_byte} << {r_gcnt, 3'b000});
                        if (i_max_delta_bytes == esd_pkg::MDB_THREE && r_gcnt >= 2'd2) begin
                            // sign-extended 24-bit delta
                            delta   = {{8{gath_or[23]}}, gath_or[23:0]};
                            have    = 1'b1;
                            n_phase = esd_pkg::PH_IDLE;
                            n_gath  = '0;
                            n_gcnt  = '0;
                        end else if (i_max_delta_bytes != esd_pkg::MDB_THREE &&
                                     r_gcnt == 2'd3) begin
                            delta   = gath_or;
                            have    = 1'b1;
                            n_phase = esd_pkg::PH_IDLE;
                            n_gath  = '0;
                            n_gcnt  = '0;
                        end else begin
                            n_gath = gath_or;
                            n_gcnt = r_gcnt + 2'd1;
                        end
                    end
                    default: begin
                        n_phase = esd_pkg::PH_IDLE;
                    end
                endcase
            end

            // accumulate, and count with saturation
            if (have) begin
                n_acc = r_acc + delta;
                if (r_done != '1) begin
                    n_done = r_done + 1'b1;
                end
            end

            o_rec_valid        = have || i_data.end_of_data;
            o_rec.raw_value    = have ? n_acc : '0;
            o_rec.sample_valid = have;
            o_rec.frame_end    = i_data.end_of_data;

            // frame end: status and clear
            if (i_data.end_of_data) begin
                if (CMP_W'(n_done) < CMP_W'(i_frame_samples)) begin
                    o_rec.status = esd_pkg::ST_SHORT;
                end else if (n_surplus) begin
                    o_rec.status = esd_pkg::ST_SURPLUS;
                end
                n_phase   = esd_pkg::PH_IDLE;
                n_gath    = '0;
                n_gcnt    = '0;
                n_acc     = '0;
                n_done    = '0;
                n_surplus = 1'b0;
            end
        end
    end

endmodule

>>> design/esd_queue.sv
// short record queue between front and back
module esd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/esd_back.sv
// back end: gain multiply stage and output register
module esd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_gain,
    input  logic              i_rec_valid,
    output logic              o_rec_pop,
    input  esd_pkg::t_rec     i_rec,
    output logic              o_valid,
    input  logic              i_ready,
    output esd_pkg::t_out_beat o_data
);

    logic               r_a_valid;
    logic signed [63:0] r_a_prod;
    logic signed [31:0] r_a_raw;
    logic               r_a_sv;
    logic               r_a_fe;
    esd_pkg::t_status   r_a_st;

    logic               r_o_valid;
    esd_pkg::t_out_beat r_o_data;

    logic               out_take;
    logic               a_take;
    logic signed [65:0] prod;

    assign out_take  = !r_o_valid || i_ready;
    assign a_take    = !r_a_valid || out_take;
    assign o_rec_pop = i_rec_valid && a_take;

    // signed sample times unsigned gain
    assign prod = $signed(i_rec.raw_value) * $signed({1'b0, i_gain});

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_take) begin
                r_a_valid <= i_rec_valid;
            end
            if (out_take) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // multiply stage payload
    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_a_prod <= prod[63:0];
            r_a_raw  <= i_rec.raw_value;
            r_a_sv   <= i_rec.sample_valid;
            r_a_fe   <= i_rec.frame_end;
            r_a_st   <= i_rec.status;
        end
    end

    // output register, scaled value drops the gain fraction
    always_ff @(posedge i_clk) begin
        if (out_take && r_a_valid) begin
            r_o_data.raw_value    <= r_a_raw;
            r_o_data.scaled_value <= r_a_prod[63:esd_pkg::GAIN_FRAC_BITS];
            r_o_data.sample_valid <= r_a_sv;
            r_o_data.frame_end    <= r_a_fe;
            r_o_data.status       <= r_a_st;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

>>> design/escaped_delta_sample_decoder.sv
// top level of the escaped delta sample decoder
//
// Input channel (i_valid/o_ready/i_data) takes one coded byte per beat with an
// end-of-data flag on the last byte of a frame. Output channel
// (o_valid/i_ready/o_data) gives one result beat for each byte that completes a
// sample or ends a frame, carrying raw and gain-scaled values, the
// sample flag, the frame end flag and the frame status.
// Throughput is one byte per cycle while the record queue has room. A byte that
// completes a sample or ends a frame is decoded by the parser in the accepting
// cycle and its record enters the queue at that edge; from there it passes the
// gain multiply register (a 32 x 33 signed product) and the output register,
// where a stall can hold it. The parser and the multiplier are
// parted by a record queue, so a stalled receiver first fills the output
// register, the multiply stage and the queue; o_ready falls only when the
// queue is full, and the flow picks up again at full rate once i_ready returns.
// Configuration (i_cfg_we/i_cfg_addr/i_cfg_wdata) writes frame_samples,
// max_delta_bytes or gain; the user writes only while the block is idle, which
// the block does not enforce. Synchronous reset clears the parser, the frame
// state, the queue and the output valid, and returns registers to reset values.
module escaped_delta_sample_decoder #(
    parameter int FRAME_COUNT_BITS = esd_pkg::FRAME_COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH      = esd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  esd_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output esd_pkg::t_out_beat o_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [31:0]        i_cfg_wdata
);

    logic [15:0] r_frame_samples;
    logic [2:0]  r_max_delta_bytes;
    logic [31:0] r_gain;

    logic          front_rec_valid;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    esd_pkg::t_rec front_rec;
    esd_pkg::t_rec q_rec;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_samples   <= esd_pkg::FRAME_SAMPLES_RST;
            r_max_delta_bytes <= esd_pkg::MAX_DELTA_BYTES_RST;
            r_gain            <= esd_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == esd_pkg::CFG_FRAME_SAMPLES) begin
                r_frame_samples <= i_cfg_wdata[15:0];
            end
            if (i_cfg_addr == esd_pkg::CFG_MAX_DELTA_BYTES) begin
                r_max_delta_bytes <= i_cfg_wdata[2:0];
            end
            if (i_cfg_addr == esd_pkg::CFG_GAIN) begin
                r_gain <= i_cfg_wdata;
            end
        end
    end

    // parser and accumulator
    esd_front #(
        .FRAME_COUNT_BITS(FRAME_COUNT_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data           (i_data),
        .i_frame_samples  (r_frame_samples),
        .i_max_delta_bytes(r_max_delta_bytes),
        .o_rec_valid      (front_rec_valid),
        .i_rec_ready      (q_ready),
        .o_rec            (front_rec)
    );

    // record queue
    esd_queue #(
        .WIDTH($bits(esd_pkg::t_rec)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (front_rec_valid),
        .i_wdata(front_rec),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_rdata(q_rec)
    );

    // scaling and output
    esd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_gain     (r_gain),
        .i_rec_valid(q_valid),
        .o_rec_pop  (q_pop),
        .i_rec      (q_rec),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

>>> design/esd_checker.sv
// port-level checks for the escaped delta sample decoder, with bind
module esd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input esd_pkg::t_out_beat o_data
);

    // a stalled output beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped while stalled");

    // status is only reported on a frame end beat
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == esd_pkg::ST_OK || o_data.frame_end))
        else $error("nonzero status without frame end");

    // a beat without a sample carries zero values
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.sample_valid |->
            (o_data.raw_value == 32'sd0 && o_data.scaled_value == 40'sd0))
        else $error("empty beat carries a value");

    // every output beat is either a sample or a frame end
    a_beat_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.sample_valid || o_data.frame_end))
        else $error("output beat with neither sample nor frame end");

    // reset empties the output side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind escaped_delta_sample_decoder esd_checker u_esd_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);

>>> sim/esd_result_checker.sv
// result checker for the escaped delta sample decoder: decode prediction and beat comparison
module esd_result_checker
    import esd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_beat    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_beat   i_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_beats,
    output int          o_samples,
    output int          o_frames,
    output int          o_short,
    output int          o_surplus
);

    // register copies
    logic [15:0] frame_len;
    logic [2:0]  width_sel;
    logic [31:0] gain_q;

    // decoder state
    t_phase      phase;
    logic [31:0] gathered;
    logic [1:0]  gcount;
    logic [31:0] acc;
    logic [15:0] done_count;
    logic        dropped;

    t_out_beat awaited_results[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_beats      = 0;
        o_samples    = 0;
        o_frames     = 0;
        o_short      = 0;
        o_surplus    = 0;
    end

    // raw times gain in Q8.24, floor, low 40 bits
    function automatic logic signed [39:0] apply_gain(logic [31:0] raw);
        logic signed [63:0] prod;
        prod = $signed({{32{raw[31]}}, raw}) * $signed({32'd0, gain_q});
        return prod[63:24];
    endfunction

    task automatic clear_frame();
        phase      = PH_IDLE;
        gathered   = '0;
        gcount     = '0;
        acc        = '0;
        done_count = '0;
        dropped    = 1'b0;
    endtask

    // one coded byte through the decoder, result when a sample completes or the frame ends
    task automatic decode_byte(input t_in_beat beat, output bit emits, output t_out_beat res);
        logic [7:0]  b;
        logic [31:0] delta;
        logic [15:0] half;
        logic [23:0] three;
        logic [1:0]  k;
        logic        have;
        int          need;
        b     = beat.data_byte;
        have  = 1'b0;
        delta = '0;
        if (done_count >= frame_len) begin
            dropped = 1'b1;
        end else begin
            case (phase)
                PH_IDLE: begin
                    if (b == ESC_BYTE) begin
                        phase    = PH_ESC16;
                        gathered = '0;
                        gcount   = '0;
                    end else begin
                        delta = {{24{b[7]}}, b};
                        have  = 1'b1;
                    end
                end
                PH_ESC16: begin
                    gathered |= 32'(b) << (8 * gcount[0]);
                    if (gcount == 2'd0) begin
                        gcount = 2'd1;
                    end else begin
                        half = gathered[15:0];
                        if (half != ESC_WORD || width_sel == MDB_TWO) begin
                            delta = {{16{half[15]}}, half};
                            have  = 1'b1;
                            phase = PH_IDLE;
                        end else begin
                            phase = PH_WIDE;
                        end
                        gathered = '0;
                        gcount   = '0;
                    end
                end
                default: begin
                    // widths other than two or three gather four bytes
                    need = (width_sel == MDB_THREE) ? 3 : 4;
                    k    = gcount;
                    gathered |= 32'(b) << (8 * k);
                    if (int'(k) + 1 >= need) begin
                        if (need == 3) begin
                            three = gathered[23:0];
                            delta = {{8{three[23]}}, three};
                        end else begin
                            delta = gathered;
                        end
                        have     = 1'b1;
                        phase    = PH_IDLE;
                        gathered = '0;
                        gcount   = '0;
                    end else begin
                        gcount = k + 2'd1;
                    end
                end
            endcase
        end

        if (have) begin
            acc = acc + delta;
            if (done_count != '1) done_count = done_count + 16'd1;
        end

        emits = have || beat.end_of_data;
        res   = '0;
        if (have) begin
            res.raw_value    = acc;
            res.scaled_value = apply_gain(acc);
            res.sample_valid = 1'b1;
        end
        res.frame_end = beat.end_of_data;
        res.status    = ST_OK;
        if (beat.end_of_data) begin
            if (done_count < frame_len) res.status = ST_SHORT;
            else if (dropped) res.status = ST_SURPLUS;
            clear_frame();
        end
    endtask

    task automatic compare_field(string name, logic signed [63:0] exp_v, logic signed [63:0] act_v);
        if (exp_v !== act_v) begin
            o_mismatches++;
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        end
    endtask

    // all channel sampling at the falling edge, ahead of the edge that takes the beat
    always @(negedge i_clk) begin
        t_out_beat want;
        t_out_beat got;
        bit        emits;
        if (!i_rst_n) begin
            frame_len = FRAME_SAMPLES_RST;
            width_sel = MAX_DELTA_BYTES_RST;
            gain_q    = GAIN_RST;
            clear_frame();
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FRAME_SAMPLES:   frame_len = i_cfg_wdata[15:0];
                    CFG_MAX_DELTA_BYTES: width_sel = i_cfg_wdata[2:0];
                    CFG_GAIN:            gain_q    = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data, emits, want);
                if (emits) awaited_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (awaited_results.size() == 0) begin
                    o_mismatches++;
                    $error("result beat with nothing expected: raw_value %0d, frame_end %0b",
                           got.raw_value, got.frame_end);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("raw_value", want.raw_value, got.raw_value);
                    compare_field("scaled_value", want.scaled_value, got.scaled_value);
                    compare_field("sample_valid", want.sample_valid, got.sample_valid);
                    compare_field("frame_end", want.frame_end, got.frame_end);
                    compare_field("status", want.status, got.status);
                    o_beats++;
                    if (want.sample_valid) o_samples++;
                    if (want.frame_end) o_frames++;
                    if (want.status == ST_SHORT) o_short++;
                    if (want.status == ST_SURPLUS) o_surplus++;
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> sim/tb_escaped_delta_sample_decoder.sv
// testbench top for the escaped delta sample decoder: stimulus, clock, reset and verdict
module tb_escaped_delta_sample_decoder;
    import esd_pkg::*;

    localparam int RANDOM_BYTES = 1730;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 8;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_in_beat    i_data      = '0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    t_out_beat   o_data;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_addr  = CFG_FRAME_SAMPLES;
    logic [31:0] i_cfg_wdata = '0;

    int mismatches, pending, beats, samples, frames, short_frames, surplus_frames;

    bit          src_gaps    = 1'b1;
    bit          sink_stalls = 1'b1;
    int          bytes_sent  = 0;
    int          cycles      = 0;
    logic [15:0] frame_len_now = FRAME_SAMPLES_RST;
    logic [2:0]  width_now     = MAX_DELTA_BYTES_RST;
    logic [7:0]  frame_bytes[$];

    escaped_delta_sample_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    esd_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_beats      (beats),
        .o_samples    (samples),
        .o_frames     (frames),
        .o_short      (short_frames),
        .o_surplus    (surplus_frames)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= !sink_stalls || ($urandom_range(0, 99) >= 35);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
            $display("** escaped_delta_sample_decoder: FAILED **");
            $finish;
        end
    end

    // one beat on the input channel, held until taken
    task automatic send_byte(logic [7:0] b, logic eod);
        logic taken;
        if (src_gaps) begin
            while ($urandom_range(0, 99) < 35) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, end_of_data: eod};
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
        bytes_sent++;
    endtask

    task automatic send_frame(bit with_end);
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], with_end && (i == frame_bytes.size() - 1));
    endtask

    // quiet input, then wait out every awaited result and let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic load_settings(logic [15:0] fs, logic [2:0] mdb, logic [31:0] g);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_FRAME_SAMPLES;
        i_cfg_wdata <= {16'd0, fs};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MAX_DELTA_BYTES;
        i_cfg_wdata <= {29'd0, mdb};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_GAIN;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_len_now = fs;
        width_now     = mdb;
    endtask

    // one sample in a random coding that the width setting allows
    task automatic add_sample(int w);
        int          kind;
        logic [7:0]  b;
        logic [15:0] v;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            b = 8'($urandom);
            if (b == ESC_BYTE) b = 8'h80;
            frame_bytes.push_back(b);
        end else if (kind < 7 || w == 2) begin
            v = 16'($urandom);
            if (w == 2 && kind == 6) v = ESC_WORD;
            else if (v == ESC_WORD) v = 16'h8000;
            frame_bytes.push_back(ESC_BYTE);
            frame_bytes.push_back(v[7:0]);
            frame_bytes.push_back(v[15:8]);
        end else begin
            frame_bytes.push_back(ESC_BYTE);
            frame_bytes.push_back(ESC_WORD[7:0]);
            frame_bytes.push_back(ESC_WORD[15:8]);
            repeat (w) frame_bytes.push_back(8'($urandom));
        end
    endtask

    // frames near the set length, 1-8 samples above 8; some short, overfull, cut or noise
    task automatic make_frame();
        int w, target, r;
        w = (width_now == MDB_TWO) ? 2 : (width_now == MDB_THREE) ? 3 : 4;
        frame_bytes.delete();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 8))
                frame_bytes.push_back(($urandom_range(0, 3) == 0) ? ESC_BYTE : 8'($urandom));
        end else begin
            r = $urandom_range(0, 9);
            if (frame_len_now > 8) target = $urandom_range(1, 8);
            else if (r < 6) target = frame_len_now;
            else if (r < 8) target = frame_len_now + $urandom_range(1, 2);
            else target = (frame_len_now > 0) ? frame_len_now - 1 : 0;
            repeat (target) add_sample(w);
            if (frame_bytes.size() > 2 && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 2)) void'(frame_bytes.pop_back());
            if (frame_bytes.size() == 0) frame_bytes.push_back(8'($urandom));
        end
    endtask

    initial begin
        int          phase_no;
        int          nframes;
        int          r;
        logic [15:0] fs;
        logic [2:0]  mdb;
        logic [31:0] g;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: single byte frame, then an overfull frame
        frame_bytes = '{8'h05};
        send_frame(1);
        frame_bytes = '{8'h80, 8'h01};
        send_frame(1);
        drain();

        // 16-bit escapes only, largest gain, frame cut inside an escape
        load_settings(16'd4, MDB_TWO, 32'hFFFF_FFFF);
        frame_bytes = '{ESC_BYTE, 8'hFF, 8'h7F, ESC_BYTE, 8'h00, 8'h80, 8'hFF, ESC_BYTE, 8'h34};
        send_frame(1);
        drain();

        // 24-bit escape to the most negative value, zero gain, cut after escape byte
        load_settings(16'd3, MDB_THREE, 32'd0);
        frame_bytes = '{ESC_BYTE, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h80, ESC_BYTE};
        send_frame(1);
        drain();

        // zero-length frame with an odd width setting
        load_settings(16'd0, 3'd7, GAIN_RST);
        frame_bytes = '{ESC_BYTE};
        send_frame(1);
        drain();

        // width narrowed while a 32-bit escape has three of its four bytes gathered
        load_settings(16'd2, 3'd4, 32'h8000_0000);
        frame_bytes = '{ESC_BYTE, 8'hFF, 8'h7F, 8'h11, 8'h22, 8'h33};
        send_frame(0);
        drain();
        load_settings(16'd2, MDB_THREE, 32'h8000_0000);
        frame_bytes = '{8'h44};
        send_frame(1);
        drain();

        // random phases, each with its own settings; phase 2 runs without any idling
        phase_no = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            r  = $urandom_range(0, 19);
            fs = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF :
                 (r == 2) ? 16'($urandom_range(9, 65534)) : 16'($urandom_range(1, 8));
            r  = $urandom_range(0, 8);
            mdb = (r < 3) ? MDB_TWO : (r < 6) ? MDB_THREE :
                  (r < 8) ? 3'd4 : 3'($urandom_range(0, 7));
            r  = $urandom_range(0, 5);
            g  = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? GAIN_RST :
                 (r == 4) ? 32'($urandom_range(0, 1 << 26)) : 32'($urandom);
            load_settings(fs, mdb, g);
            src_gaps    = (phase_no != 2);
            sink_stalls = (phase_no != 2);
            nframes     = (phase_no == 2) ? 40 : $urandom_range(1, 5);
            for (int f = 0; f < nframes; f++) begin
                make_frame();
                // the last frame of a phase sometimes stays open across the settings change
                send_frame(!(f == nframes - 1 && $urandom_range(0, 4) == 0));
            end
            drain();
            phase_no++;
        end

        frame_bytes = '{8'h00};
        send_frame(1);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        drain();

        $display("run covered %0d coded bytes in %0d setting phases", bytes_sent, phase_no + 6);
        $display("checked %0d result beats: %0d samples, %0d frames (%0d short, %0d surplus)",
                 beats, samples, frames, short_frames, surplus_frames);
        if (mismatches == 0 && pending == 0) begin
            $display("** escaped_delta_sample_decoder: PASSED **");
        end else begin
            $display("** escaped_delta_sample_decoder: FAILED **");
        end
        $finish;
    end

endmodule
